// File: rtl/core/lsws_pkg.sv
`timescale 1ns / 1ps

package lsws_pkg;

   // Sizing
   localparam int MAX_BEAMS     = 4096;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int NUM_CELLS     = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

   localparam int IDX_W     = 12;
   localparam int ANGLE_W   = 16;
   localparam int RANGE_W   = 16;
   localparam int POS_W     = 32;
   localparam int GAIN_W    = 30;
   localparam int GAIN_SHIFT = 14;
   localparam int XMAG_W    = RANGE_W + GAIN_W - GAIN_SHIFT;
   localparam int XY_W      = 36;
   localparam int Z_W       = 33;
   localparam int FRAC_W    = 16;
   localparam int RND_W     = XY_W - FRAC_W;
   localparam int STAGE_W   = 5;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   typedef logic        [IDX_W-1:0]   idx_type;
   typedef logic        [ANGLE_W-1:0] angle_type;
   typedef logic        [RANGE_W-1:0] range_type;
   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [POS_W:0]     wpos_type;
   typedef logic signed [XY_W-1:0]    xy_type;
   typedef logic signed [Z_W-1:0]     z_type;
   typedef logic signed [RND_W-1:0]   rnd_type;
   typedef logic        [STAGE_W-1:0] stage_type;
   typedef logic        [DATA_W-1:0]  data_type;

   localparam idx_type   BEAM_LIMIT = idx_type'(((MAX_BEAMS > 4096) ? 4096 : MAX_BEAMS) - 1);
   localparam logic [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(652032874);
   localparam angle_type QUARTER_TURN = angle_type'(1) << (ANGLE_W - 2);
   localparam angle_type HALF_TURN    = angle_type'(1) << (ANGLE_W - 1);
   localparam xy_type    ROUND_BIAS   = xy_type'(1) << (FRAC_W - 1);
   localparam pos_type   POS_MAX      = {1'b0, {(POS_W-1){1'b1}}};
   localparam pos_type   POS_MIN      = {1'b1, {(POS_W-1){1'b0}}};

   typedef enum logic [2:0] {
      REG_ANGLE_START    = 3'd0,
      REG_ANGLE_STEP     = 3'd1,
      REG_SENSOR_HEADING = 3'd2,
      REG_SENSOR_POS_X   = 3'd3,
      REG_SENSOR_POS_Y   = 3'd4
   } reg_index_type;

   typedef struct packed {
      angle_type angle_start;
      angle_type angle_step;
      angle_type heading;
      pos_type   pos_x;
      pos_type   pos_y;
   } cfg_type;

   // One word travelling down the CORDIC chain
   typedef struct packed {
      logic    valid;
      xy_type  x;
      xy_type  y;
      z_type   z;
      idx_type idx;
      logic    last;
   } cell_type;

   // atan(2^-i) in 1/2^32 turn
   function automatic z_type atan_turn(input stage_type stage);
      z_type val;
      case (stage)
         5'd0:    val = z_type'(536870912);
         5'd1:    val = z_type'(316933406);
         5'd2:    val = z_type'(167458907);
         5'd3:    val = z_type'(85004756);
         5'd4:    val = z_type'(42667331);
         5'd5:    val = z_type'(21354465);
         5'd6:    val = z_type'(10679838);
         5'd7:    val = z_type'(5340245);
         5'd8:    val = z_type'(2670163);
         5'd9:    val = z_type'(1335087);
         5'd10:   val = z_type'(667544);
         5'd11:   val = z_type'(333772);
         5'd12:   val = z_type'(166886);
         5'd13:   val = z_type'(83443);
         5'd14:   val = z_type'(41722);
         5'd15:   val = z_type'(20861);
         5'd16:   val = z_type'(10430);
         5'd17:   val = z_type'(5215);
         5'd18:   val = z_type'(2608);
         5'd19:   val = z_type'(1304);
         5'd20:   val = z_type'(652);
         5'd21:   val = z_type'(326);
         5'd22:   val = z_type'(163);
         5'd23:   val = z_type'(81);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/lsws_front.sv
`timescale 1ns / 1ps

// Beam counter, phase build, gain scaling and half-plane fold.
module lsws_front (
   input  logic              clock,
   input  logic              reset,
   input  lsws_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  lsws_pkg::range_type in_range,
   input  logic              in_last,
   output lsws_pkg::cell_type out_data,
   input  logic              out_ready
);

   lsws_pkg::idx_type   beam_count_ff, beam_count_in;
   logic                s1_valid_ff;
   lsws_pkg::range_type s1_range_ff;
   lsws_pkg::angle_type s1_phase_ff;
   lsws_pkg::idx_type   s1_idx_ff;
   logic                s1_last_ff;
   lsws_pkg::cell_type  out_ff, out_in;

   logic                s1_ready, s2_ready, accept;
   logic [lsws_pkg::IDX_W+lsws_pkg::ANGLE_W-1:0]  step_prod;
   lsws_pkg::angle_type phase_in, phase_rot, quad;
   logic [lsws_pkg::RANGE_W+lsws_pkg::GAIN_W-1:0] gain_prod;
   logic [lsws_pkg::XMAG_W-1:0] x_mag;
   lsws_pkg::xy_type    x_pos;
   logic                flip;

   assign s2_ready = !out_ff.valid || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;
   assign accept   = in_valid && s1_ready;
   assign out_data = out_ff;

   always_comb begin
      step_prod = {{lsws_pkg::ANGLE_W{1'b0}}, beam_count_ff}
                * {{lsws_pkg::IDX_W{1'b0}}, cfg.angle_step};
      phase_in  = cfg.angle_start + step_prod[lsws_pkg::ANGLE_W-1:0] + cfg.heading;

      beam_count_in = beam_count_ff;
      if (accept) begin
         if (in_last) begin
            beam_count_in = '0;
         end else if (beam_count_ff < lsws_pkg::BEAM_LIMIT) begin
            beam_count_in = beam_count_ff + 1'b1;
         end else begin
            beam_count_in = lsws_pkg::BEAM_LIMIT;
         end
      end
   end

   // stage 2: x0 = range*K >> 14, fold left half-plane onto the right
   always_comb begin
      gain_prod = {{lsws_pkg::GAIN_W{1'b0}}, s1_range_ff}
                * {{lsws_pkg::RANGE_W{1'b0}}, lsws_pkg::GAIN_Q30};
      x_mag     = gain_prod[lsws_pkg::RANGE_W+lsws_pkg::GAIN_W-1:lsws_pkg::GAIN_SHIFT];
      x_pos     = lsws_pkg::xy_type'(x_mag);
      quad      = s1_phase_ff + lsws_pkg::QUARTER_TURN;
      flip      = quad[lsws_pkg::ANGLE_W-1];
      phase_rot = flip ? (s1_phase_ff + lsws_pkg::HALF_TURN) : s1_phase_ff;

      out_in       = out_ff;
      out_in.valid = s1_valid_ff;
      out_in.x     = flip ? -x_pos : x_pos;
      out_in.y     = '0;
      out_in.z     = lsws_pkg::z_type'($signed({phase_rot, {lsws_pkg::ANGLE_W{1'b0}}}));
      out_in.idx   = s1_idx_ff;
      out_in.last  = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_count_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else begin
         beam_count_ff <= beam_count_in;
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            out_ff <= out_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_range_ff <= in_range;
         s1_phase_ff <= phase_in;
         s1_idx_ff   <= beam_count_ff;
         s1_last_ff  <= in_last;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> beam_count_ff == '0)
      else $error("beam counter not cleared after scan end");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && !in_last && beam_count_ff != lsws_pkg::BEAM_LIMIT
      |=> beam_count_ff == $past(beam_count_ff) + 1'b1)
      else $error("beam counter did not advance");

endmodule

// File: rtl/core/lsws_cell.sv
`timescale 1ns / 1ps

// One CORDIC rotation step, registered.
module lsws_cell (
   input  logic                clock,
   input  logic                reset,
   input  lsws_pkg::stage_type stage_idx,
   input  lsws_pkg::cell_type  in_data,
   output logic                in_ready,
   output lsws_pkg::cell_type  out_data,
   input  logic                out_ready
);

   lsws_pkg::cell_type out_ff, out_in;
   lsws_pkg::xy_type   x_cur, y_cur, dx, dy;
   lsws_pkg::z_type    z_cur, ang;

   assign in_ready = !out_ff.valid || out_ready;
   assign out_data = out_ff;

   always_comb begin
      x_cur  = in_data.x;
      y_cur  = in_data.y;
      z_cur  = in_data.z;
      dx     = y_cur >>> stage_idx;
      dy     = x_cur >>> stage_idx;
      ang    = lsws_pkg::atan_turn(stage_idx);
      out_in = in_data;
      if (!z_cur[lsws_pkg::Z_W-1]) begin
         out_in.x = x_cur - dx;
         out_in.y = y_cur + dy;
         out_in.z = z_cur - ang;
      end else begin
         out_in.x = x_cur + dx;
         out_in.y = y_cur - dy;
         out_in.z = z_cur + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (in_ready) begin
         out_ff <= out_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_ff.valid && !out_ready |=> out_ff.valid && $stable(out_ff))
      else $error("cell dropped or changed a stalled word");

endmodule

// File: rtl/core/lsws_back.sv
`timescale 1ns / 1ps

// Round to mm, add sensor position, saturate, chain segments.
module lsws_back (
   input  logic               clock,
   input  logic               reset,
   input  lsws_pkg::cfg_type  cfg,
   input  lsws_pkg::cell_type in_data,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output lsws_pkg::pos_type  start_x,
   output lsws_pkg::pos_type  start_y,
   output lsws_pkg::pos_type  end_x,
   output lsws_pkg::pos_type  end_y,
   output lsws_pkg::idx_type  seg_idx,
   output logic               scan_end
);

   logic               rnd_valid_ff;
   lsws_pkg::rnd_type  rnd_x_ff, rnd_y_ff;
   lsws_pkg::idx_type  rnd_idx_ff;
   logic               rnd_last_ff;

   logic               out_valid_ff;
   lsws_pkg::pos_type  start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   lsws_pkg::idx_type  idx_ff;
   logic               last_ff;
   lsws_pkg::pos_type  prev_x_ff, prev_y_ff;

   logic               out_load, rnd_ready;
   lsws_pkg::xy_type   sum_rx, sum_ry;
   lsws_pkg::wpos_type sum_wx, sum_wy;
   lsws_pkg::pos_type  wx_in, wy_in;

   assign out_load  = !out_valid_ff || out_ready;
   assign rnd_ready = !rnd_valid_ff || out_load;
   assign in_ready  = rnd_ready;

   assign out_valid = out_valid_ff;
   assign start_x   = start_x_ff;
   assign start_y   = start_y_ff;
   assign end_x     = end_x_ff;
   assign end_y     = end_y_ff;
   assign seg_idx   = idx_ff;
   assign scan_end  = last_ff;

   always_comb begin
      sum_rx = in_data.x + lsws_pkg::ROUND_BIAS;
      sum_ry = in_data.y + lsws_pkg::ROUND_BIAS;

      sum_wx = lsws_pkg::wpos_type'(cfg.pos_x) + lsws_pkg::wpos_type'(rnd_x_ff);
      sum_wy = lsws_pkg::wpos_type'(cfg.pos_y) + lsws_pkg::wpos_type'(rnd_y_ff);

      if (sum_wx[lsws_pkg::POS_W] != sum_wx[lsws_pkg::POS_W-1]) begin
         wx_in = sum_wx[lsws_pkg::POS_W] ? lsws_pkg::POS_MIN : lsws_pkg::POS_MAX;
      end else begin
         wx_in = sum_wx[lsws_pkg::POS_W-1:0];
      end
      if (sum_wy[lsws_pkg::POS_W] != sum_wy[lsws_pkg::POS_W-1]) begin
         wy_in = sum_wy[lsws_pkg::POS_W] ? lsws_pkg::POS_MIN : lsws_pkg::POS_MAX;
      end else begin
         wy_in = sum_wy[lsws_pkg::POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
      end else begin
         if (rnd_ready) begin
            rnd_valid_ff <= in_data.valid;
         end
         if (out_load) begin
            out_valid_ff <= rnd_valid_ff;
            if (rnd_valid_ff) begin
               prev_x_ff <= wx_in;
               prev_y_ff <= wy_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rnd_ready && in_data.valid) begin
         rnd_x_ff    <= sum_rx[lsws_pkg::XY_W-1:lsws_pkg::FRAC_W];
         rnd_y_ff    <= sum_ry[lsws_pkg::XY_W-1:lsws_pkg::FRAC_W];
         rnd_idx_ff  <= in_data.idx;
         rnd_last_ff <= in_data.last;
      end
      if (out_load && rnd_valid_ff) begin
         end_x_ff   <= wx_in;
         end_y_ff   <= wy_in;
         start_x_ff <= (rnd_idx_ff == '0) ? wx_in : prev_x_ff;
         start_y_ff <= (rnd_idx_ff == '0) ? wy_in : prev_y_ff;
         idx_ff     <= rnd_idx_ff;
         last_ff    <= rnd_last_ff;
      end
   end

   a_first_point: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && idx_ff == '0 |-> start_x_ff == end_x_ff && start_y_ff == end_y_ff)
      else $error("first segment of a scan is not a point");

endmodule

// File: rtl/core/lidar_scan_to_world_segments.sv
`timescale 1ns / 1ps

// Lidar scan to world segments. Each req word is one range sample (mm); the
// block counts beams itself, so beam angle = angle_start + index*angle_step,
// and tlast on req closes the scan and zeroes the count. The sample is
// rotated by beam angle plus sensor_heading in a CORDIC (angles in 1/65536
// turn), rounded to mm, offset by the sensor position and saturated to 32 bits.
// Each rsp word is the segment from the previous world point to this one; the
// first beam of a scan gives a zero-length segment. Throughput is one word
// per clock while rsp is not stalled: the CORDIC is a chain of cells, one
// rotation step each. There are NUM_CELLS + 4 register stages. Stalls on rsp
// fill bubbles first, then back up to req_tready.
// Registers (32-bit APB, byte address 4*i): 0 angle_start, 1 angle_step,
// 2 sensor_heading, 3 sensor_pos_x, 4 sensor_pos_y; all reset to zero. The
// user must see that they are written only while the pipe is empty; the
// block does not enforce this.
module lidar_scan_to_world_segments (
   input  logic                         clock,
   input  logic                         reset,

   // req_tdata: [15:0] range_mm; req_tlast: last_beam
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [15:0]                  req_tdata,
   input  logic                         req_tlast,

   // rsp_tdata: [31:0] start_x, [63:32] start_y, [95:64] end_x,
   //            [127:96] end_y, [139:128] segment_index, [143:140] zero
   // rsp_tlast: scan_end
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [143:0]                 rsp_tdata,
   output logic                         rsp_tlast,

   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lsws_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [lsws_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [lsws_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);

   // Config registers
   lsws_pkg::angle_type angle_start_ff, angle_step_ff, heading_ff;
   lsws_pkg::pos_type   pos_x_ff, pos_y_ff;
   lsws_pkg::cfg_type   cfg;
   lsws_pkg::reg_index_type csr_index;
   logic                csr_write;

   // Chain links: [0] from the front end, [NUM_CELLS] into the back end
   lsws_pkg::cell_type  chain_data  [lsws_pkg::NUM_CELLS+1];
   logic                chain_ready [lsws_pkg::NUM_CELLS+1];

   lsws_pkg::pos_type   start_x, start_y, end_x, end_y;
   lsws_pkg::idx_type   seg_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = lsws_pkg::reg_index_type'(csr_paddr[lsws_pkg::ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_start_ff <= '0;
         angle_step_ff  <= '0;
         heading_ff     <= '0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            lsws_pkg::REG_ANGLE_START:    angle_start_ff <= csr_pwdata[lsws_pkg::ANGLE_W-1:0];
            lsws_pkg::REG_ANGLE_STEP:     angle_step_ff  <= csr_pwdata[lsws_pkg::ANGLE_W-1:0];
            lsws_pkg::REG_SENSOR_HEADING: heading_ff     <= csr_pwdata[lsws_pkg::ANGLE_W-1:0];
            lsws_pkg::REG_SENSOR_POS_X:   pos_x_ff       <= csr_pwdata[lsws_pkg::POS_W-1:0];
            lsws_pkg::REG_SENSOR_POS_Y:   pos_y_ff       <= csr_pwdata[lsws_pkg::POS_W-1:0];
            default: ;  // unmapped: dropped
         endcase
      end
   end

   // Readback; angle_start is signed and reads sign-extended
   always_comb begin
      unique case (csr_index)
         lsws_pkg::REG_ANGLE_START:
            csr_prdata = lsws_pkg::data_type'($signed(angle_start_ff));
         lsws_pkg::REG_ANGLE_STEP:     csr_prdata = lsws_pkg::data_type'(angle_step_ff);
         lsws_pkg::REG_SENSOR_HEADING: csr_prdata = lsws_pkg::data_type'(heading_ff);
         lsws_pkg::REG_SENSOR_POS_X:   csr_prdata = pos_x_ff;
         lsws_pkg::REG_SENSOR_POS_Y:   csr_prdata = pos_y_ff;
         default:                      csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.angle_start = angle_start_ff;
      cfg.angle_step  = angle_step_ff;
      cfg.heading     = heading_ff;
      cfg.pos_x       = pos_x_ff;
      cfg.pos_y       = pos_y_ff;
   end

   // Front end: beam index, phase, K scaling, quadrant fold (2 stages)
   lsws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_range  (req_tdata),
      .in_last   (req_tlast),
      .out_data  (chain_data[0]),
      .out_ready (chain_ready[0])
   );

   // CORDIC chain, one rotation step per cell
   for (genvar g = 0; g < lsws_pkg::NUM_CELLS; g++) begin : g_cell
      lsws_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (lsws_pkg::stage_type'(g)),
         .in_data   (chain_data[g]),
         .in_ready  (chain_ready[g]),
         .out_data  (chain_data[g+1]),
         .out_ready (chain_ready[g+1])
      );
   end

   // Back end: round, offset, saturate, segment chaining (2 stages)
   lsws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_data   (chain_data[lsws_pkg::NUM_CELLS]),
      .in_ready  (chain_ready[lsws_pkg::NUM_CELLS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .start_x   (start_x),
      .start_y   (start_y),
      .end_x     (end_x),
      .end_y     (end_y),
      .seg_idx   (seg_idx),
      .scan_end  (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, seg_idx, end_y, end_x, start_y, start_x};

endmodule

// File: tb/lidar_scan_to_world_segments_tb.sv
`timescale 1ns / 1ps

module lidar_scan_to_world_segments_tb;
   import lsws_pkg::*;

   // req accept edge to rsp valid
   localparam int LATENCY = NUM_CELLS + 3;

   // atan(2^-i) in 1/2^32 turn
   localparam longint ATAN_TURN [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   typedef struct packed {
      pos_type start_x;
      pos_type start_y;
      pos_type end_x;
      pos_type end_y;
      idx_type index;
      logic    scan_end;
   } segment_word_type;

   typedef enum logic [1:0] {
      ROW_CFG,          // register write, pipe drained first
      ROW_ITEM,         // range word, checked against the predictor
      ROW_ITEM_TYPED    // range word with the segment typed in below
   } row_kind_type;

   // data is the register value for ROW_CFG, else range_mm in [15:0]
   typedef struct packed {
      row_kind_type  kind;
      reg_index_type csr;
      logic [31:0]   data;
      logic          last;
      pos_type       want_x;
      pos_type       want_y;
      idx_type       want_index;
   } directed_row_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC,
      READY_STARVED
   } stall_mode_type;

   localparam int NUM_ROWS = 30;

   // Typed rows are all range 0 on beam 0: the point is the sensor position
   // and the segment has zero length.
   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // registers at reset
      '{ROW_ITEM_TYPED, REG_ANGLE_START,    32'h0,        1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd65535,    1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd1,        1'b1, 32'h0, 32'h0, 12'd0},
      // first beam and scan end in one word
      '{ROW_ITEM_TYPED, REG_ANGLE_START,    32'h0,        1'b1, 32'h0, 32'h0, 12'd0},
      // position extremes, then saturation on x
      '{ROW_CFG,        REG_SENSOR_POS_X,   32'h7FFFFFFF, 1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_CFG,        REG_SENSOR_POS_Y,   32'h80000000, 1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM_TYPED, REG_ANGLE_START,    32'h0,        1'b0, POS_MAX, POS_MIN, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd65535,    1'b0, 32'h0, 32'h0, 12'd0},
      // half turn heading, saturation toward the negative end
      '{ROW_CFG,        REG_SENSOR_HEADING, 32'h8000,     1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_CFG,        REG_SENSOR_POS_X,   32'h80000000, 1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_CFG,        REG_SENSOR_POS_Y,   32'h7FFFFFFF, 1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd65535,    1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'h0,        1'b1, 32'h0, 32'h0, 12'd0},
      // most negative start, full-scale step, quarter turn heading
      '{ROW_CFG,        REG_ANGLE_START,    32'h8000,     1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_CFG,        REG_ANGLE_STEP,     32'hFFFF,     1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_CFG,        REG_SENSOR_HEADING, 32'h4000,     1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_CFG,        REG_SENSOR_POS_X,   32'h0,        1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_CFG,        REG_SENSOR_POS_Y,   32'h0,        1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd65535,    1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd32768,    1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd1,        1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd65535,    1'b1, 32'h0, 32'h0, 12'd0},
      // most positive start, quarter step, heading right on the -1/4 fold
      '{ROW_CFG,        REG_ANGLE_START,    32'h7FFF,     1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_CFG,        REG_ANGLE_STEP,     32'h4000,     1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_CFG,        REG_SENSOR_HEADING, 32'hC000,     1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd43690,    1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd21845,    1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd65535,    1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd12345,    1'b0, 32'h0, 32'h0, 12'd0},
      '{ROW_ITEM,       REG_ANGLE_START,    32'd65535,    1'b1, 32'h0, 32'h0, 12'd0}
   };

   // DUT ports; the inputs are all known from time zero
   logic                clock;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata   = '0;
   logic                req_tlast   = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [143:0]        rsp_tdata;
   logic                rsp_tlast;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr   = '0;
   logic [DATA_W-1:0]   csr_pwdata  = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   // predictor state: register shadow, beam counter, last world point
   cfg_type             cfg_shadow  = '0;
   idx_type             beam_index  = '0;
   pos_type             last_point_x = '0;
   pos_type             last_point_y = '0;

   segment_word_type    pending_segments [$];
   int                  mismatch_count = 0;
   int                  rsp_count      = 0;
   int                  burst_left     = 0;

   stall_mode_type      stall_mode  = READY_ALWAYS;
   logic [31:0]         ready_cycle = '0;

   segment_word_type    rsp_got;
   segment_word_type    rsp_want;

   lidar_scan_to_world_segments dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic pos_type clamp_mm(input longint v);
      if (v > longint'(POS_MAX))
         return POS_MAX;
      if (v < longint'(POS_MIN))
         return POS_MIN;
      return pos_type'(v);
   endfunction

   // Beam angle from the counter, fold into [-1/4, 1/4) turn, CORDIC rotate
   // the gain-scaled range, round to mm, offset by the sensor and chain.
   function automatic segment_word_type predict_segment(input range_type range_mm,
                                                        input logic last_beam);
      segment_word_type seg;
      idx_type       idx;
      angle_type     phase;
      logic [31:0]   ph;
      logic [31:0]   fold;
      logic [63:0]   prod;
      longint        x, y, z, dx, dy, off_x, off_y;
      pos_type       wx, wy;
      int            i;

      idx   = (beam_index > BEAM_LIMIT) ? BEAM_LIMIT : beam_index;
      phase = cfg_shadow.angle_start + idx * cfg_shadow.angle_step + cfg_shadow.heading;

      ph   = {phase, 16'h0};
      prod = {48'h0, range_mm} * 64'd652032874;
      x    = longint'(prod >> 14);
      y    = 0;
      fold = ph + 32'h4000_0000;
      if (fold[31]) begin
         x  = -x;
         ph = ph + 32'h8000_0000;
      end
      z = longint'($signed(ph));

      for (i = 0; i < NUM_CELLS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURN[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURN[i];
         end
      end
      off_x = (x + 32768) >>> 16;
      off_y = (y + 32768) >>> 16;

      wx = clamp_mm(longint'($signed(cfg_shadow.pos_x)) + off_x);
      wy = clamp_mm(longint'($signed(cfg_shadow.pos_y)) + off_y);

      seg.start_x  = (idx == '0) ? wx : last_point_x;
      seg.start_y  = (idx == '0) ? wy : last_point_y;
      seg.end_x    = wx;
      seg.end_y    = wy;
      seg.index    = idx;
      seg.scan_end = last_beam;

      last_point_x = wx;
      last_point_y = wy;
      if (last_beam)
         beam_index = '0;
      else if (idx < BEAM_LIMIT)
         beam_index = idx + 1'b1;
      else
         beam_index = BEAM_LIMIT;
      return seg;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch on rsp word %0d, %s: got %0d, want %0d",
               rsp_count, field, got, want);
      mismatch_count++;
   endtask

   // Sender: bursts of random length, random gaps in between. Valid stays
   // high across back-to-back words inside a burst.
   task automatic send_range_word(input range_type range_mm, input logic last_beam,
                                  input logic typed, input segment_word_type typed_seg);
      int               gap;
      segment_word_type seg;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= range_mm;
      req_tlast  <= last_beam;
      do @(posedge clock); while (req_tready !== 1'b1);
      seg = predict_segment(range_mm, last_beam);
      pending_segments.insert(pending_segments.size(), typed ? typed_seg : seg);
      burst_left--;
   endtask

   // Config goes in only with the pipe empty; every word makes a segment,
   // so an empty queue means nothing is in flight.
   task automatic wait_pipe_empty();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_segments.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write_reg(input reg_index_type csr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(int'(csr) * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (csr)
         REG_ANGLE_START:    cfg_shadow.angle_start = data[15:0];
         REG_ANGLE_STEP:     cfg_shadow.angle_step  = data[15:0];
         REG_SENSOR_HEADING: cfg_shadow.heading     = data[15:0];
         REG_SENSOR_POS_X:   cfg_shadow.pos_x       = data;
         REG_SENSOR_POS_Y:   cfg_shadow.pos_y       = data;
         default: ;
      endcase
      // idle cycle so the next setup phase lands in a fresh step
      @(posedge clock);
   endtask

   function automatic range_type pick_range();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 16'hFFFF;
         2:       return range_type'($urandom_range(0, 255));
         default: return range_type'($urandom);
      endcase
   endfunction

   // angles near the fold points and the ends of the range
   function automatic angle_type pick_angle();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'h4000;
         2:       return 16'h8000;
         3:       return 16'hC000;
         4:       return 16'hFFFF;
         5:       return 16'h7FFF;
         6:       return angle_type'($urandom_range(0, 3));
         default: return angle_type'($urandom);
      endcase
   endfunction

   // positions at and near saturation, near zero, or anywhere
   function automatic pos_type pick_pos();
      case ($urandom_range(0, 7))
         0:       return POS_MAX;
         1:       return POS_MIN;
         2:       return '0;
         3:       return pos_type'(int'($urandom_range(0, 200000)) - 100000);
         4:       return POS_MAX - pos_type'($urandom_range(0, 70000));
         5:       return POS_MIN + pos_type'($urandom_range(0, 70000));
         default: return pos_type'($urandom);
      endcase
   endfunction

   task automatic write_random_config();
      wait_pipe_empty();
      csr_write_reg(REG_ANGLE_START,    {16'h0, pick_angle()});
      csr_write_reg(REG_ANGLE_STEP,     {16'h0, pick_angle()});
      csr_write_reg(REG_SENSOR_HEADING, {16'h0, pick_angle()});
      csr_write_reg(REG_SENSOR_POS_X,   pick_pos());
      csr_write_reg(REG_SENSOR_POS_Y,   pick_pos());
   endtask

   // Receiver stall pattern, changes mode now and then
   always @(posedge clock) begin
      ready_cycle <= ready_cycle + 1;
      if (ready_cycle % 97 == 0)
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_RANDOM:   rsp_tready <= ($urandom_range(0, 2) != 0);
         READY_PERIODIC: rsp_tready <= (ready_cycle[2:0] != 3'd5);
         READY_STARVED:  rsp_tready <= ($urandom_range(0, 5) == 0);
         default:        rsp_tready <= 1'b1;
      endcase
   end

   // Result checker: each accepted rsp word against the oldest segment
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         rsp_got.start_x  = rsp_tdata[31:0];
         rsp_got.start_y  = rsp_tdata[63:32];
         rsp_got.end_x    = rsp_tdata[95:64];
         rsp_got.end_y    = rsp_tdata[127:96];
         rsp_got.index    = rsp_tdata[139:128];
         rsp_got.scan_end = rsp_tlast;
         if (pending_segments.size() == 0) begin
            report_mismatch("word with no segment pending", 0, 0);
         end else begin
            rsp_want = pending_segments.pop_front();
            if (rsp_got.start_x !== rsp_want.start_x)
               report_mismatch("start_x", rsp_got.start_x, rsp_want.start_x);
            if (rsp_got.start_y !== rsp_want.start_y)
               report_mismatch("start_y", rsp_got.start_y, rsp_want.start_y);
            if (rsp_got.end_x !== rsp_want.end_x)
               report_mismatch("end_x", rsp_got.end_x, rsp_want.end_x);
            if (rsp_got.end_y !== rsp_want.end_y)
               report_mismatch("end_y", rsp_got.end_y, rsp_want.end_y);
            if (rsp_got.index !== rsp_want.index)
               report_mismatch("segment_index", rsp_got.index, rsp_want.index);
            if (rsp_got.scan_end !== rsp_want.scan_end)
               report_mismatch("scan_end", rsp_got.scan_end, rsp_want.scan_end);
            if (rsp_tdata[143:140] !== 4'h0)
               report_mismatch("tdata pad", rsp_tdata[143:140], 0);
         end
         rsp_count++;
      end
   end

   initial begin
      int               row;
      int               phase;
      int               n;
      int               scan_left;
      segment_word_type typed_seg;

      scan_left = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (row = 0; row < NUM_ROWS; row++) begin
         typed_seg.start_x  = DIRECTED_ROWS[row].want_x;
         typed_seg.start_y  = DIRECTED_ROWS[row].want_y;
         typed_seg.end_x    = DIRECTED_ROWS[row].want_x;
         typed_seg.end_y    = DIRECTED_ROWS[row].want_y;
         typed_seg.index    = DIRECTED_ROWS[row].want_index;
         typed_seg.scan_end = DIRECTED_ROWS[row].last;
         case (DIRECTED_ROWS[row].kind)
            ROW_CFG: begin
               wait_pipe_empty();
               csr_write_reg(DIRECTED_ROWS[row].csr, DIRECTED_ROWS[row].data);
            end
            ROW_ITEM_TYPED:
               send_range_word(DIRECTED_ROWS[row].data[15:0], DIRECTED_ROWS[row].last,
                               1'b1, typed_seg);
            default:
               send_range_word(DIRECTED_ROWS[row].data[15:0], DIRECTED_ROWS[row].last,
                               1'b0, typed_seg);
         endcase
      end

      // Random scans; scan lengths run across config phases on purpose
      for (phase = 0; phase < 8; phase++) begin
         write_random_config();
         for (n = 0; n < 68; n++) begin
            if (scan_left == 0)
               scan_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
            scan_left--;
            send_range_word(pick_range(), scan_left == 0, 1'b0, typed_seg);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
      // catch any stray word after the last expected one
      repeat (2 * LATENCY) @(posedge clock);

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
